[hw/rtl/rrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDE_MODE = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    // One decoded run as it leaves the decoder.
    typedef struct packed {
        logic        truncated;
        logic        image_done;
        logic [31:0] run_length;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } rrd_result_t;

    // Settings and re-arm requests from the configuration block.
    typedef struct packed {
        logic        wide_mode;
        logic        write_strobe;
        logic [31:0] write_total;
        logic        write_empty;
        logic [31:0] total;
        logic        empty;
    } rrd_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/rrd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrd_cfg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output rrd_pkg::rrd_cfg_t cfg_out
);
    import rrd_pkg::*;

    logic        wide_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] total_reg;
    logic        empty_reg;

    logic        wr_en;
    logic        known_index;
    logic [15:0] width_sel;
    logic [15:0] height_sel;
    logic [31:0] total_sel;
    logic        empty_sel;

    assign cfg_ready   = 1'b1;
    assign known_index = (cfg_index == CFG_WIDE_MODE) || (cfg_index == CFG_WIDTH) ||
                         (cfg_index == CFG_HEIGHT);
    assign wr_en       = cfg_valid && known_index;

    // The new pixel count is formed from the value being written so the
    // decoder can re-arm in the same edge.
    assign width_sel  = (cfg_index == CFG_WIDTH)  ? cfg_data : width_reg;
    assign height_sel = (cfg_index == CFG_HEIGHT) ? cfg_data : height_reg;
    assign total_sel  = {16'd0, width_sel} * {16'd0, height_sel};
    assign empty_sel  = (width_sel == 16'd0) || (height_sel == 16'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg   <= 1'b0;
            width_reg  <= 16'd320;
            height_reg <= 16'd200;
            total_reg  <= 32'd64000;
            empty_reg  <= 1'b0;
        end else if (wr_en) begin
            if (cfg_index == CFG_WIDE_MODE) begin
                wide_reg <= cfg_data[0];
            end
            width_reg  <= width_sel;
            height_reg <= height_sel;
            total_reg  <= total_sel;
            empty_reg  <= empty_sel;
        end
    end

    assign cfg_out.wide_mode    = wide_reg;
    assign cfg_out.write_strobe = wr_en;
    assign cfg_out.write_total  = total_sel;
    assign cfg_out.write_empty  = empty_sel;
    assign cfg_out.total        = total_reg;
    assign cfg_out.empty        = empty_reg;

endmodule

`default_nettype wire

[hw/rtl/rrd_parse.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrd_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire rrd_pkg::rrd_cfg_t cfg_in,
    output logic                   res_valid,
    output rrd_pkg::rrd_result_t   res
);
    import rrd_pkg::*;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_BLUE   = 3'd2;
    localparam logic [2:0] PH_COUNT  = 3'd3;
    localparam logic [2:0] PH_EXT    = 3'd4;
    localparam logic [2:0] PH_HIGH   = 3'd5;
    localparam logic [2:0] PH_LOW    = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  high_reg, high_next;
    logic [31:0] left_reg, left_next;
    logic        fin_reg, fin_next;

    logic [31:0] count;
    logic [31:0] run;
    logic [31:0] left_dec;
    logic        emit;
    logic        done;
    logic        trunc;

    // A nibble times 17 is the nibble repeated in both halves of the byte.
    always_comb begin
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        high_next  = high_reg;
        left_next  = left_reg;
        fin_next   = fin_reg;
        count      = 32'd0;
        emit       = 1'b0;
        done       = 1'b0;
        run        = 32'd0;
        left_dec   = left_reg;

        if (!fin_reg) begin
            unique case (phase_reg)
                PH_SECOND: begin
                    if (cfg_in.wide_mode) begin
                        green_next = in_byte;
                        phase_next = PH_BLUE;
                    end else begin
                        blue_next = {in_byte[7:4], in_byte[7:4]};
                        count     = {29'd0, in_byte[2:0]};
                        if (count != 32'd0) begin
                            emit = 1'b1;
                        end else begin
                            phase_next = PH_EXT;
                        end
                    end
                end
                PH_BLUE: begin
                    blue_next  = in_byte;
                    phase_next = PH_COUNT;
                end
                PH_COUNT: begin
                    count = {25'd0, in_byte[6:0]};
                    if (count != 32'd0) begin
                        emit = 1'b1;
                    end else begin
                        phase_next = PH_EXT;
                    end
                end
                PH_EXT: begin
                    count = {24'd0, in_byte};
                    if (count != 32'd0) begin
                        emit = 1'b1;
                    end else begin
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    high_next  = in_byte;
                    phase_next = PH_LOW;
                end
                PH_LOW: begin
                    count = {16'd0, high_reg, in_byte};
                    if (count == 32'd0) begin
                        count = left_reg;
                    end
                    emit = 1'b1;
                end
                default: begin
                    // First color byte; the unused phase code behaves the same.
                    if (cfg_in.wide_mode) begin
                        red_next = in_byte;
                    end else begin
                        red_next   = {in_byte[7:4], in_byte[7:4]};
                        green_next = {in_byte[3:0], in_byte[3:0]};
                    end
                    phase_next = PH_SECOND;
                end
            endcase

            run      = (count < left_reg) ? count : left_reg;
            left_dec = left_reg - run;
            if (emit) begin
                left_next  = left_dec;
                phase_next = PH_FIRST;
                if (left_dec == 32'd0) begin
                    fin_next = 1'b1;
                    done     = 1'b1;
                end
            end
        end

        trunc = in_last && !fin_next;

        if (in_last) begin
            phase_next = PH_FIRST;
            left_next  = cfg_in.total;
            fin_next   = cfg_in.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            red_reg   <= 8'd0;
            green_reg <= 8'd0;
            blue_reg  <= 8'd0;
            high_reg  <= 8'd0;
            left_reg  <= 32'd64000;
            fin_reg   <= 1'b0;
        end else if (cfg_in.write_strobe) begin
            phase_reg <= PH_FIRST;
            left_reg  <= cfg_in.write_total;
            fin_reg   <= cfg_in.write_empty;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            high_reg  <= high_next;
            left_reg  <= left_next;
            fin_reg   <= fin_next;
        end
    end

    assign res_valid      = in_accept && (emit || trunc);
    assign res.red        = emit ? red_next   : 8'd0;
    assign res.green      = emit ? green_next : 8'd0;
    assign res.blue       = emit ? blue_next  : 8'd0;
    assign res.run_length = emit ? run        : 32'd0;
    assign res.image_done = done;
    assign res.truncated  = trunc;

endmodule

`default_nettype wire

[hw/rtl/rrd_obuf.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrd_obuf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire rrd_pkg::rrd_result_t push_data,
    output logic                      space,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rrd_pkg::rrd_result_t      out_data
);
    import rrd_pkg::*;

    rrd_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    // Space is taken from the fill count alone, so the input side never
    // waits on the receiver's ready in the same cycle.
    assign space     = (fill_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rgbn_rgb8_run_decoder.sv]
// Run decoder for 24-bit run-length image bodies in 4-bit and 8-bit color forms.
// The s_ channel takes one compressed byte per beat; s_tlast marks the final
// byte of the body chunk. Each completed record gives one beat on the m_
// channel with the run color and its length, clipped to the pixels still
// missing out of width times height. When the chunk ends early, the beat that
// closes it carries the truncated flag (run length 0 if no run completed).
// Bytes after the image is complete give no beat until the chunk ends.
// The cfg channel writes mode (index 0), width (1) and height (2); any write
// to these indexes re-arms the decoder and drops a record in progress.
// cfg_ready is always high. A byte's result enters the output queue at the
// edge that accepts the byte. One byte is taken every cycle while s_tready is
// high: the record update is one combinational step with one 32-bit compare
// and subtract. A two-beat output queue lets the input run while a result
// waits; s_tready falls only when both entries are held by a stalled receiver.
// Reset empties the queue, selects 4-bit records and a 320 by 200 image.
`timescale 1ns / 1ps
`default_nettype none

module rgbn_rgb8_run_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // chunk_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [55:24] run_length
    output logic [1:0]       m_tuser,   // [0] image_done, [1] truncated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import rrd_pkg::*;

    rrd_cfg_t    cfg_bus;
    rrd_result_t res;
    rrd_result_t out_res;
    logic        res_valid;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    rrd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg_bus)
    );

    rrd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cfg_in    (cfg_bus),
        .res_valid (res_valid),
        .res       (res)
    );

    rrd_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.run_length, out_res.blue, out_res.green, out_res.red};
    assign m_tuser = {out_res.truncated, out_res.image_done};

endmodule

`default_nettype wire

[hw/rtl/rrd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A held beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // A beat without a run is a truncation report with a blank color.
    a_empty_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[55:24] == 32'd0) |->
            m_tuser[1] && !m_tuser[0] && (m_tdata[23:0] == 24'd0))
        else $error("zero-length run that is not a truncation report");

    // A run that completes the image cannot also report missing pixels.
    a_done_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("image_done and truncated both set");

endmodule

bind rgbn_rgb8_run_decoder rrd_checker u_rrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
